>>> hdl/bffa_pkg.sv
// Package for the bitmap first-free allocator: word types, constants,
// controller state and the command and status groups.
// Used by every module under hdl; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bffa_pkg;

  localparam int LIMIT_W                = 13;
  localparam int NUMBER_W               = 16;
  localparam int GROUP_W                = 3;
  localparam int WORD_BITS              = 64;
  localparam int WORD_SHIFT             = 6;
  localparam int DEFAULT_GROUPS         = 8;
  localparam int DEFAULT_BITS_PER_GROUP = 4096;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  localparam logic OP_INODE = 1'b0;
  localparam logic OP_BLOCK = 1'b1;

  localparam logic CFG_INODES_PER_GROUP = 1'b0;
  localparam logic CFG_BLOCKS_PER_GROUP = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [GROUP_W-1:0] group;
  } req_t;

  typedef struct packed {
    logic                allocated;
    logic [NUMBER_W-1:0] number;
    logic [LIMIT_W-1:0]  group_free;
    logic [NUMBER_W-1:0] total_free;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SET,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic scan;
    logic set;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic skip;
    logic hit;
    logic miss;
    logic rsp_free;
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/bffa_ctrl.sv
// Controller state machine of the bitmap first-free allocator.
// Drives the datapath commands from its status; uses bffa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bffa_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_stall,
  input  bffa_pkg::sts_t   sts,
  output bffa_pkg::cmd_t   cmd
);
  import bffa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = sts.skip ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.hit) state_next = ST_SET;
        else if (sts.miss) state_next = ST_FINISH;
      end
      ST_SET: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.rsp_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    req_stall  = (state != ST_IDLE);
    cmd.clear  = (state == ST_CLEAR);
    cmd.accept = (state == ST_IDLE) && req_valid;
    cmd.scan   = (state == ST_SCAN);
    cmd.set    = (state == ST_SET);
    cmd.finish = (state == ST_FINISH) && sts.rsp_free;
  end

endmodule

`default_nettype wire

>>> hdl/bffa_datapath.sv
// Datapath of the bitmap first-free allocator: limit registers, bitmap
// memory, scan pipeline, used counters and the result register. Uses bffa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bffa_datapath #(
  parameter int GROUPS         = bffa_pkg::DEFAULT_GROUPS,
  parameter int BITS_PER_GROUP = bffa_pkg::DEFAULT_BITS_PER_GROUP
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_write_en,
  input  wire                              cfg_index,
  input  wire [bffa_pkg::LIMIT_W-1:0]      cfg_data,
  input  bffa_pkg::req_t                   req,
  output bffa_pkg::rsp_t                   rsp,
  output logic                             rsp_valid,
  input  wire                              rsp_stall,
  input  bffa_pkg::cmd_t                   cmd,
  output bffa_pkg::sts_t                   sts
);
  import bffa_pkg::*;

  localparam int MAX_REACH   = 2 ** GROUP_W;
  localparam int USED_GROUPS = (GROUPS < MAX_REACH) ? GROUPS : MAX_REACH;
  localparam int GRP_W       = (USED_GROUPS > 1) ? $clog2(USED_GROUPS) : 1;
  localparam int WORDS       = BITS_PER_GROUP / WORD_BITS;
  localparam int WORD_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int MEM_AW      = 1 + GRP_W + WORD_W;
  localparam int MEM_DEPTH   = 2 ** MEM_AW;
  localparam int CW          = (WORD_W + 7 > LIMIT_W) ? WORD_W + 7 : LIMIT_W;
  localparam int CAP_W       = LIMIT_W + $clog2(GROUPS + 1);
  localparam int TW          = (CAP_W > NUMBER_W) ? CAP_W : NUMBER_W;

  logic [LIMIT_W-1:0]  inodes_per_group;
  logic [LIMIT_W-1:0]  blocks_per_group;

  logic [WORD_BITS-1:0] map_mem [MEM_DEPTH];
  logic [WORD_BITS-1:0] rdata;
  logic [MEM_AW-1:0]    raddr;
  logic [MEM_AW-1:0]    waddr;
  logic [WORD_BITS-1:0] wdata;
  logic                 mem_we;
  logic [MEM_AW-1:0]    clr_addr;

  logic                 kind;
  logic [GRP_W-1:0]     grp;
  logic                 in_range;
  logic [LIMIT_W-1:0]   lim;
  logic [WORD_W:0]      rd_word;
  logic [WORD_W-1:0]    chk_word;
  logic                 chk_valid;
  logic [WORD_W-1:0]    hit_word;
  logic [WORD_BITS-1:0] hold_word;
  logic [WORD_BITS-1:0] hold_free;
  logic                 alloc;
  logic [NUMBER_W-1:0]  number;

  logic [LIMIT_W-1:0]   inode_used [USED_GROUPS];
  logic [LIMIT_W-1:0]   block_used [USED_GROUPS];
  logic [NUMBER_W-1:0]  inode_total;
  logic [NUMBER_W-1:0]  block_total;

  logic [LIMIT_W-1:0]   lim_raw;
  logic [LIMIT_W-1:0]   lim_in;
  logic                 range_in;
  logic [CW-1:0]        rd_base;
  logic                 rd_more;
  logic [CW-1:0]        chk_rem;
  logic                 chk_last;
  logic [WORD_BITS-1:0] chk_mask;
  logic [WORD_BITS-1:0] freebits;
  logic                 any_free;
  logic [WORD_SHIFT-1:0] bit_idx;
  logic [LIMIT_W-1:0]   used_g;
  logic [NUMBER_W-1:0]  used_t;
  logic [LIMIT_W-1:0]   gfree;
  logic [CAP_W-1:0]     cap;
  logic [TW-1:0]        tdiff;
  logic [NUMBER_W-1:0]  tfree;

  always_ff @(posedge clk) begin
    if (rst) begin
      inodes_per_group <= LIMIT_RESET;
      blocks_per_group <= LIMIT_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_INODES_PER_GROUP: inodes_per_group <= cfg_data;
        CFG_BLOCKS_PER_GROUP: blocks_per_group <= cfg_data;
      endcase
    end
  end

  always_comb begin
    lim_raw  = (req.opcode == OP_BLOCK) ? blocks_per_group : inodes_per_group;
    lim_in   = lim_raw;
    if (int'(lim_raw) > BITS_PER_GROUP) lim_in = LIMIT_W'(BITS_PER_GROUP);
    range_in = int'(req.group) < GROUPS;
  end

  always_comb begin
    rd_base  = CW'({rd_word, {WORD_SHIFT{1'b0}}});
    rd_more  = rd_base < CW'(lim);
    chk_rem  = CW'(lim) - CW'({chk_word, {WORD_SHIFT{1'b0}}});
    chk_last = chk_rem <= CW'(WORD_BITS);
    if (chk_rem >= CW'(WORD_BITS)) begin
      chk_mask = '1;
    end else begin
      chk_mask = (WORD_BITS'(1) << chk_rem[WORD_SHIFT-1:0]) - WORD_BITS'(1);
    end
    freebits = ~rdata & chk_mask;
    any_free = |freebits;
  end

  always_comb begin
    bit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hold_free[i]) bit_idx = WORD_SHIFT'(i);
    end
  end

  always_comb begin
    raddr  = {kind, grp, rd_word[WORD_W-1:0]};
    mem_we = cmd.clear || cmd.set;
    if (cmd.clear) begin
      waddr = clr_addr;
      wdata = '0;
    end else begin
      waddr = {kind, grp, hit_word};
      wdata = hold_word | (WORD_BITS'(1) << bit_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) map_mem[waddr] <= wdata;
    rdata <= map_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + MEM_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (cmd.accept) begin
      chk_valid <= 1'b0;
    end else if (cmd.scan) begin
      chk_valid <= rd_more;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind     <= req.opcode;
      grp      <= GRP_W'(req.group);
      in_range <= range_in;
      lim      <= lim_in;
      rd_word  <= '0;
      alloc    <= 1'b0;
      number   <= '0;
    end else if (cmd.scan) begin
      chk_word <= rd_word[WORD_W-1:0];
      if (rd_more) rd_word <= rd_word + (WORD_W + 1)'(1);
      if (chk_valid && any_free) begin
        hit_word  <= chk_word;
        hold_word <= rdata;
        hold_free <= freebits;
      end
    end else if (cmd.set) begin
      alloc  <= 1'b1;
      number <= NUMBER_W'(grp) * NUMBER_W'(lim)
              + NUMBER_W'({hit_word, bit_idx})
              + ((kind == OP_INODE) ? NUMBER_W'(1) : NUMBER_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < USED_GROUPS; g++) begin
        inode_used[g] <= '0;
        block_used[g] <= '0;
      end
      inode_total <= '0;
      block_total <= '0;
    end else if (cmd.set) begin
      if (kind == OP_BLOCK) begin
        if (block_used[grp] != '1) block_used[grp] <= block_used[grp] + LIMIT_W'(1);
        if (block_total != '1) block_total <= block_total + NUMBER_W'(1);
      end else begin
        if (inode_used[grp] != '1) inode_used[grp] <= inode_used[grp] + LIMIT_W'(1);
        if (inode_total != '1) inode_total <= inode_total + NUMBER_W'(1);
      end
    end
  end

  always_comb begin
    used_g = (kind == OP_BLOCK) ? block_used[grp] : inode_used[grp];
    used_t = (kind == OP_BLOCK) ? block_total : inode_total;
    if (!in_range || used_g >= lim) gfree = '0;
    else gfree = lim - used_g;
    cap = CAP_W'(GROUPS) * CAP_W'(lim);
    if (TW'(used_t) >= TW'(cap)) tdiff = '0;
    else tdiff = TW'(cap) - TW'(used_t);
    if (tdiff > TW'(16'hFFFF)) tfree = '1;
    else tfree = tdiff[NUMBER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.allocated  <= alloc;
      rsp.number     <= number;
      rsp.group_free <= gfree;
      rsp.total_free <= tfree;
    end
  end

  always_comb begin
    sts            = '0;
    sts.clear_done = &clr_addr;
    sts.skip       = !range_in || (lim_in == '0);
    sts.hit        = cmd.scan && chk_valid && any_free;
    sts.miss       = cmd.scan && chk_valid && !any_free && chk_last;
    sts.rsp_free   = !rsp_valid || !rsp_stall;
  end

endmodule

`default_nettype wire

>>> hdl/bitmap_first_free_allocator_top.sv
// Top level of the bitmap first-free allocator: controller and datapath.
// Uses bffa_pkg, bffa_ctrl and bffa_datapath.
//
// Request words (req, opcode and group) enter on req_valid/req_stall, result
// words (rsp) leave on rsp_valid/rsp_stall; one result word per request.
// cfg_write_en with cfg_index and cfg_data writes inodes_per_group (index 0)
// or blocks_per_group (index 1); write only while the block is idle.
// One request is worked at a time. The scan reads one 64-bit bitmap word per
// cycle through the memory read port, ceil(limit/64) words at most, and
// checks each word in the cycle after its read. A request that hits goes
// from ST_SCAN through ST_SET to ST_FINISH, which loads the result; a miss
// goes from ST_SCAN to ST_FINISH. An out-of-range group or a zero limit
// skips the scan and goes from ST_IDLE to ST_FINISH. A new request is taken
// in the cycle after the result is loaded, so a waiting result does not
// hold off the next request. After reset the bitmap memory is cleared one
// word a cycle over 2 * 2**(group bits + word bits) words, 1024 words at the
// defaults, with req_stall high. When the receiver stalls, rsp holds and
// the block waits to load the next result until the held one is taken.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_first_free_allocator_top #(
  parameter int GROUPS         = bffa_pkg::DEFAULT_GROUPS,
  parameter int BITS_PER_GROUP = bffa_pkg::DEFAULT_BITS_PER_GROUP
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         req_valid,
  output logic                        req_stall,
  input  bffa_pkg::req_t              req,
  output logic                        rsp_valid,
  input  wire                         rsp_stall,
  output bffa_pkg::rsp_t              rsp,
  input  wire                         cfg_write_en,
  input  wire                         cfg_index,
  input  wire [bffa_pkg::LIMIT_W-1:0] cfg_data
);
  import bffa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bffa_datapath #(
    .GROUPS         (GROUPS),
    .BITS_PER_GROUP (BITS_PER_GROUP)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req          (req),
    .rsp          (rsp),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

`default_nettype wire
